[design/prq_pkg.sv]
package prq_pkg;

  localparam logic [1:0] CMD_CREATE  = 2'd0;
  localparam logic [1:0] CMD_TICK    = 2'd1;
  localparam logic [1:0] CMD_DEQUEUE = 2'd2;

  // cell operations
  localparam logic [1:0] OP_HOLD  = 2'd0;
  localparam logic [1:0] OP_NEW   = 2'd1;
  localparam logic [1:0] OP_LEFT  = 2'd2;
  localparam logic [1:0] OP_RIGHT = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  task_id;
    logic [7:0]  priority_req;
    logic [15:0] arrival_delay;
  } in_item_t;

  typedef struct packed {
    logic       preempt;
    logic       head_valid;
    logic [3:0] head_task;
    logic [4:0] ready_count;
  } out_item_t;

endpackage

[design/priority_ready_queue_with_arrival_delay_top.sv]
// Priority ready queue with arrival delay.
// Input: pulse start with in_item while busy is low; the transaction is
// accepted at that edge. Commands: create, tick, dequeue.
// Output: out_valid is high for exactly one cycle with out_item; the
// receiver cannot stall, so results are never held.
// Flow: create, dequeue and the unused code go from EXEC to DONE, where
// out_valid is high. A tick walks the waiting list one entry per cycle in
// WALK, but moving an entry into the ready list adds a MOVE step before
// the walk goes on; WALK goes to DONE once it sees the end of the list.
// busy is high from accept through the result cycle; the next transaction
// is taken back in IDLE, after DONE, so a new one cannot be taken before
// the last is through. Both lists are built as rows of cells that shift
// to insert and remove.
// Reset (rst_n low, synchronous) empties both lists; no clearing pass.
module priority_ready_queue_with_arrival_delay_top #(
  parameter int MAX_TASKS  = 16,
  parameter int PRIO_BITS  = 8,
  parameter int DELAY_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  prq_pkg::in_item_t  in_item,
  output logic               busy,
  output logic               out_valid,
  output prq_pkg::out_item_t out_item
);
  localparam int LW = $clog2(MAX_TASKS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_WALK = 3'd2;
  localparam logic [2:0] S_MOVE = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [1:0]  cmd_r;
  logic [3:0]  id_r;
  logic [PRIO_BITS-1:0]  prio_r;
  logic [DELAY_BITS-1:0] dly_r;
  logic [LW-1:0] rlen_r, wlen_r, ptr_r;
  logic pre_r, hv_r;
  logic [3:0] ht_r;

  logic r_ins, r_rem, w_ins, w_rem, w_upd, r_head, w_head;
  logic [3:0] r_nid;
  logic [PRIO_BITS-1:0] r_nprio;
  logic [3:0] rids [MAX_TASKS];
  logic [PRIO_BITS-1:0] rprios [MAX_TASKS];
  logic [DELAY_BITS-1:0] rdlys [MAX_TASKS];
  logic [3:0] wids [MAX_TASKS];
  logic [PRIO_BITS-1:0] wprios [MAX_TASKS];
  logic [DELAY_BITS-1:0] wdlys [MAX_TASKS];
  logic [DELAY_BITS-1:0] cur_d, dec_d;
  logic rfull, wfull;

  assign rfull = rlen_r >= LW'(MAX_TASKS);
  assign wfull = wlen_r >= LW'(MAX_TASKS);
  assign cur_d = wdlys[ptr_r[$clog2(MAX_TASKS)-1:0]];
  assign dec_d = (cur_d != '0) ? cur_d - 1'b1 : cur_d;

  always_comb begin
    r_ins = 1'b0; r_rem = 1'b0; w_ins = 1'b0; w_rem = 1'b0; w_upd = 1'b0;
    r_nid = id_r; r_nprio = prio_r;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (start) state_nxt = S_EXEC;
      S_EXEC: begin
        state_nxt = S_DONE;
        case (cmd_r)
          prq_pkg::CMD_CREATE: begin
            if (dly_r == '0) r_ins = !rfull;
            else w_ins = !wfull;
          end
          prq_pkg::CMD_TICK: state_nxt = S_WALK;
          prq_pkg::CMD_DEQUEUE: r_rem = rlen_r != '0;
          default: ;
        endcase
      end
      S_WALK: begin
        if (ptr_r >= wlen_r) state_nxt = S_DONE;
        else if (dec_d == '0 && !rfull) begin
          r_ins = 1'b1;
          r_nid = wids[ptr_r[$clog2(MAX_TASKS)-1:0]];
          r_nprio = wprios[ptr_r[$clog2(MAX_TASKS)-1:0]];
          state_nxt = S_MOVE;
        end else w_upd = 1'b1;
      end
      S_MOVE: begin
        w_rem = 1'b1;
        state_nxt = S_WALK;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  prq_list #(.N(MAX_TASKS), .PW(PRIO_BITS), .DW(DELAY_BITS), .LW(LW)) u_ready (
    .clk(clk), .len(rlen_r), .ins(r_ins), .rem(r_rem), .upd(1'b0), .idx('0),
    .new_id(r_nid), .new_prio(r_nprio), .new_dly('0), .ins_at_head(r_head),
    .ids(rids), .prios(rprios), .dlys(rdlys)
  );

  prq_list #(.N(MAX_TASKS), .PW(PRIO_BITS), .DW(DELAY_BITS), .LW(LW)) u_wait (
    .clk(clk), .len(wlen_r), .ins(w_ins), .rem(w_rem), .upd(w_upd), .idx(ptr_r),
    .new_id(id_r), .new_prio(prio_r), .new_dly(w_upd ? dec_d : dly_r),
    .ins_at_head(w_head), .ids(wids), .prios(wprios), .dlys(wdlys)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rlen_r <= '0;
      wlen_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (r_ins) rlen_r <= rlen_r + 1'b1;
      if (r_rem) rlen_r <= rlen_r - 1'b1;
      if (w_ins) wlen_r <= wlen_r + 1'b1;
      if (w_rem) wlen_r <= wlen_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      cmd_r  <= in_item.cmd;
      id_r   <= in_item.task_id;
      prio_r <= PRIO_BITS'(in_item.priority_req);
      dly_r  <= DELAY_BITS'(in_item.arrival_delay);
      ptr_r  <= '0;
      pre_r  <= 1'b0;
      hv_r   <= 1'b0;
      ht_r   <= '0;
    end else begin
      if (r_ins && r_head) pre_r <= 1'b1;
      if (r_rem) begin
        hv_r <= 1'b1;
        ht_r <= rids[0];
      end
      // removed entry: next one slides into ptr, so ptr holds
      if (w_upd) ptr_r <= ptr_r + 1'b1;
    end
  end

  assign busy = state_r != S_IDLE;
  assign out_valid = state_r == S_DONE;
  assign out_item.preempt = pre_r;
  assign out_item.head_valid = hv_r;
  assign out_item.head_task = ht_r;
  assign out_item.ready_count = 5'(rlen_r);

  logic unused;
  assign unused = w_head ^ (^rprios[0]) ^ (^rdlys[0]);

  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    rlen_r <= LW'(MAX_TASKS) && wlen_r <= LW'(MAX_TASKS)) else $error("len overflow");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    !(r_ins && r_rem)) else $error("ready conflict");
  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double result");
  a_hv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.head_valid |-> out_item.head_task == '0) else $error("head");
endmodule

[design/prq_cell.sv]
// One slot of a sorted list. Handles insert (shift right), pop/remove (shift left).
module prq_cell #(
  parameter int PW = 8,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [1:0]    op,       // hold, take own new value, take left, take right
  input  logic [3:0]    new_id,
  input  logic [PW-1:0] new_prio,
  input  logic [DW-1:0] new_dly,
  input  logic [3:0]    l_id,
  input  logic [PW-1:0] l_prio,
  input  logic [DW-1:0] l_dly,
  input  logic [3:0]    r_id,
  input  logic [PW-1:0] r_prio,
  input  logic [DW-1:0] r_dly,
  output logic [3:0]    id_r,
  output logic [PW-1:0] prio_r,
  output logic [DW-1:0] dly_r
);
  always_ff @(posedge clk) begin
    if (en) begin
      case (op)
        prq_pkg::OP_NEW: begin id_r <= new_id; prio_r <= new_prio; dly_r <= new_dly; end
        prq_pkg::OP_LEFT: begin id_r <= l_id;   prio_r <= l_prio;   dly_r <= l_dly;   end
        prq_pkg::OP_RIGHT: begin id_r <= r_id;   prio_r <= r_prio;   dly_r <= r_dly;   end
        default: ;
      endcase
    end
  end
endmodule

[design/prq_list.sv]
// Sorted list built from a row of cells. One command per cycle:
// insert (sorted, after equal priorities), remove entry at index, or
// write the delay of entry at index.
module prq_list #(
  parameter int N  = 16,
  parameter int PW = 8,
  parameter int DW = 16,
  parameter int LW = 5
) (
  input  logic          clk,
  input  logic [LW-1:0] len,
  input  logic          ins,
  input  logic          rem,
  input  logic          upd,
  input  logic [LW-1:0] idx,
  input  logic [3:0]    new_id,
  input  logic [PW-1:0] new_prio,
  input  logic [DW-1:0] new_dly,
  output logic          ins_at_head,
  output logic [3:0]    ids   [N],
  output logic [PW-1:0] prios [N],
  output logic [DW-1:0] dlys  [N]
);
  logic [N-1:0] gt;
  logic [1:0]   op [N];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      gt[i] = (LW'(i) < len) && (new_prio < prios[i]);
    end
    ins_at_head = gt[0];
    for (int i = 0; i < N; i++) begin
      op[i] = prq_pkg::OP_HOLD;
      if (ins) begin
        if (LW'(i) <= len) begin
          if (i == 0) op[i] = gt[0] || (len == '0) ? prq_pkg::OP_NEW : prq_pkg::OP_HOLD;
          else if (gt[i-1]) op[i] = prq_pkg::OP_LEFT;
          else if (gt[i] || LW'(i) == len) op[i] = prq_pkg::OP_NEW;
        end
      end else if (rem) begin
        if (LW'(i) >= idx && i < N-1) op[i] = prq_pkg::OP_RIGHT;
      end else if (upd) begin
        if (LW'(i) == idx) op[i] = prq_pkg::OP_NEW;
      end
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    prq_cell #(.PW(PW), .DW(DW)) u_cell (
      .clk(clk), .en(1'b1), .op(op[g]),
      .new_id(upd ? ids[g] : new_id),
      .new_prio(upd ? prios[g] : new_prio),
      .new_dly(new_dly),
      .l_id(ids[(g+N-1)%N]), .l_prio(prios[(g+N-1)%N]), .l_dly(dlys[(g+N-1)%N]),
      .r_id(ids[(g+1)%N]), .r_prio(prios[(g+1)%N]), .r_dly(dlys[(g+1)%N]),
      .id_r(ids[g]), .prio_r(prios[g]), .dly_r(dlys[g])
    );
  end
endmodule
